// File: rtl/whp_pkg.sv
// Shared types and constants for the WAV header chunk parser.
`timescale 1ns / 1ps
package whp_pkg;

   localparam int WINDOW_BYTES_DEF = 8192;
   localparam int OFFS_W           = 34;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_RIFF   = 3'd1;
   localparam logic [2:0] ST_NO_WAVE   = 3'd2;
   localparam logic [2:0] ST_NO_FMT    = 3'd3;
   localparam logic [2:0] ST_FMT_LATE  = 3'd4;
   localparam logic [2:0] ST_NOT_PCM   = 3'd5;
   localparam logic [2:0] ST_NO_DATA   = 3'd6;
   localparam logic [2:0] ST_BAD_DEPTH = 3'd7;

   // Tags as little-endian 32-bit words
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] FMT_PCM  = 16'd1;
   localparam logic [15:0] DEPTH_16 = 16'd16;
   localparam logic [15:0] DEPTH_24 = 16'd24;

   // Last byte index of a fetch
   localparam logic [1:0] LAST_HALF = 2'd1;
   localparam logic [1:0] LAST_WORD = 2'd3;

   typedef enum logic [3:0] {
      PH_LOAD,
      PH_RIFF,
      PH_WAVE,
      PH_FMT_SEEK,
      PH_FMT_HOP,
      PH_FMT_CHECK,
      PH_CHANS,
      PH_RATE,
      PH_DEPTH,
      PH_FMT_LEAVE,
      PH_DATA_SEEK,
      PH_DATA_HOP,
      PH_DATA_SIZE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] channel_count;
      logic [31:0] rate_hz;
      logic        depth_class;
      logic [13:0] data_start;
      logic [32:0] data_stop;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [OFFS_W-1:0] base;
      logic [1:0]        last;
   } fetch_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } fetch_rsp_type;

endpackage

// File: rtl/whp_window_ram.sv
// Byte window memory: one write port, one registered read port.
`timescale 1ns / 1ps
module whp_window_ram #(
   parameter int DEPTH  = whp_pkg::WINDOW_BYTES_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/whp_byte_fetch.sv
// Little-endian multi-byte reader over the window; bytes past the fill read as zero.
`timescale 1ns / 1ps
module whp_byte_fetch #(
   parameter int WINDOW_BYTES = whp_pkg::WINDOW_BYTES_DEF,
   parameter int ADDR_W       = $clog2(WINDOW_BYTES),
   parameter int FILL_W       = $clog2(WINDOW_BYTES + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  whp_pkg::fetch_req_type fetch_req,
   output whp_pkg::fetch_rsp_type fetch_rsp,
   input  logic [FILL_W-1:0]      fill_count,
   output logic                   rd_en,
   output logic [ADDR_W-1:0]      rd_addr,
   input  logic [7:0]             rd_data
);

   localparam int OW = whp_pkg::OFFS_W;

   logic          busy_ff, busy_in;
   logic          wait_ff, wait_in;
   logic          done_ff, done_in;
   logic          hit_ff, hit_in;
   logic [1:0]    idx_ff, idx_in;
   logic [1:0]    last_ff, last_in;
   logic [OW-1:0] base_ff, base_in;
   logic [31:0]   acc_ff, acc_in;
   logic [OW-1:0] addr;
   logic [7:0]    byte_val;

   assign addr     = base_ff + {{(OW-2){1'b0}}, idx_ff};
   assign rd_en    = busy_ff && !wait_ff;
   assign rd_addr  = addr[ADDR_W-1:0];
   assign byte_val = hit_ff ? rd_data : 8'h00;

   always_comb begin
      busy_in = busy_ff;
      wait_in = wait_ff;
      done_in = 1'b0;
      hit_in  = hit_ff;
      idx_in  = idx_ff;
      last_in = last_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      if (fetch_req.start) begin
         busy_in = 1'b1;
         wait_in = 1'b0;
         idx_in  = 2'd0;
         last_in = fetch_req.last;
         base_in = fetch_req.base;
         acc_in  = 32'h0;
      end else if (busy_ff && !wait_ff) begin
         // fill never exceeds the window, so one compare covers both limits
         hit_in  = addr < {{(OW-FILL_W){1'b0}}, fill_count};
         wait_in = 1'b1;
      end else if (busy_ff) begin
         acc_in[{idx_ff, 3'b000} +: 8] = byte_val;
         wait_in = 1'b0;
         if (idx_ff == last_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         wait_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         wait_ff <= wait_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff  <= hit_in;
      idx_ff  <= idx_in;
      last_ff <= last_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
   end

   assign fetch_rsp.done  = done_ff;
   assign fetch_rsp.value = acc_ff;

endmodule

// File: rtl/whp_walker.sv
// Chunk walk sequencer: tag checks, fmt field capture, data chunk search.
`timescale 1ns / 1ps
module whp_walker #(
   parameter int WINDOW_BYTES = whp_pkg::WINDOW_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic                   res_take,
   output logic                   busy,
   output logic                   res_valid,
   output whp_pkg::rsp_type       res_data,
   output whp_pkg::fetch_req_type fetch_req,
   input  whp_pkg::fetch_rsp_type fetch_rsp
);

   localparam int OW = whp_pkg::OFFS_W;
   localparam logic [OW-1:0] SEEK_LIMIT = OW'(WINDOW_BYTES - 8);
   localparam logic [OW-1:0] FMT_LIMIT  = OW'(WINDOW_BYTES - 24);

   whp_pkg::phase_type phase_ff, phase_in;
   logic          sent_ff, sent_in;
   logic [OW-1:0] scan_ff, scan_in;
   logic [2:0]    status_ff, status_in;
   logic [15:0]   chans_ff, chans_in;
   logic [31:0]   rate_ff, rate_in;
   logic [15:0]   depth_ff, depth_in;
   logic [13:0]   start_ff, start_in;
   logic [32:0]   stop_ff, stop_in;

   logic          seek_oob;
   logic          fmt_oob;
   logic [31:0]   v;
   logic [OW-1:0] hop;
   logic [OW-1:0] data_begin;
   logic [OW-1:0] data_end;
   logic          depth_ok;

   assign seek_oob   = scan_ff > SEEK_LIMIT;
   assign fmt_oob    = scan_ff > FMT_LIMIT;
   assign v          = fetch_rsp.value;
   assign hop        = scan_ff + {2'b00, v} + OW'(8);
   assign data_begin = scan_ff + OW'(8);
   assign data_end   = data_begin + {2'b00, v};
   assign depth_ok   = (depth_ff == whp_pkg::DEPTH_16) || (depth_ff == whp_pkg::DEPTH_24);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      sent_in   = sent_ff;
      scan_in   = scan_ff;
      status_in = status_ff;
      chans_in  = chans_ff;
      rate_in   = rate_ff;
      depth_in  = depth_ff;
      start_in  = start_ff;
      stop_in   = stop_ff;
      if (fetch_req.start) begin
         sent_in = 1'b1;
      end
      if (fetch_rsp.done) begin
         sent_in = 1'b0;
      end
      case (phase_ff)
         whp_pkg::PH_LOAD: begin
            if (go) begin
               phase_in = whp_pkg::PH_RIFF;
               sent_in  = 1'b0;
            end
         end
         whp_pkg::PH_RIFF: begin
            if (fetch_rsp.done) begin
               if (v == whp_pkg::TAG_RIFF) begin
                  phase_in = whp_pkg::PH_WAVE;
               end else begin
                  status_in = whp_pkg::ST_NO_RIFF;
                  phase_in  = whp_pkg::PH_DONE;
               end
            end
         end
         whp_pkg::PH_WAVE: begin
            if (fetch_rsp.done) begin
               if (v == whp_pkg::TAG_WAVE) begin
                  scan_in  = OW'(12);
                  phase_in = whp_pkg::PH_FMT_SEEK;
               end else begin
                  status_in = whp_pkg::ST_NO_WAVE;
                  phase_in  = whp_pkg::PH_DONE;
               end
            end
         end
         whp_pkg::PH_FMT_SEEK: begin
            if (!sent_ff && seek_oob) begin
               status_in = whp_pkg::ST_NO_FMT;
               phase_in  = whp_pkg::PH_DONE;
            end else if (fetch_rsp.done) begin
               phase_in = (v == whp_pkg::TAG_FMT) ? whp_pkg::PH_FMT_CHECK
                                                  : whp_pkg::PH_FMT_HOP;
            end
         end
         whp_pkg::PH_FMT_HOP: begin
            if (fetch_rsp.done) begin
               scan_in  = hop;
               phase_in = whp_pkg::PH_FMT_SEEK;
            end
         end
         whp_pkg::PH_FMT_CHECK: begin
            if (!sent_ff && fmt_oob) begin
               status_in = whp_pkg::ST_FMT_LATE;
               phase_in  = whp_pkg::PH_DONE;
            end else if (fetch_rsp.done) begin
               if (v[15:0] == whp_pkg::FMT_PCM) begin
                  phase_in = whp_pkg::PH_CHANS;
               end else begin
                  status_in = whp_pkg::ST_NOT_PCM;
                  phase_in  = whp_pkg::PH_DONE;
               end
            end
         end
         whp_pkg::PH_CHANS: begin
            if (fetch_rsp.done) begin
               chans_in = v[15:0];
               phase_in = whp_pkg::PH_RATE;
            end
         end
         whp_pkg::PH_RATE: begin
            if (fetch_rsp.done) begin
               rate_in  = v;
               phase_in = whp_pkg::PH_DEPTH;
            end
         end
         whp_pkg::PH_DEPTH: begin
            if (fetch_rsp.done) begin
               depth_in = v[15:0];
               phase_in = whp_pkg::PH_FMT_LEAVE;
            end
         end
         whp_pkg::PH_FMT_LEAVE: begin
            if (fetch_rsp.done) begin
               scan_in  = hop;
               phase_in = whp_pkg::PH_DATA_SEEK;
            end
         end
         whp_pkg::PH_DATA_SEEK: begin
            if (!sent_ff && seek_oob) begin
               status_in = whp_pkg::ST_NO_DATA;
               phase_in  = whp_pkg::PH_DONE;
            end else if (fetch_rsp.done) begin
               phase_in = (v == whp_pkg::TAG_DATA) ? whp_pkg::PH_DATA_SIZE
                                                   : whp_pkg::PH_DATA_HOP;
            end
         end
         whp_pkg::PH_DATA_HOP: begin
            if (fetch_rsp.done) begin
               scan_in  = hop;
               phase_in = whp_pkg::PH_DATA_SEEK;
            end
         end
         whp_pkg::PH_DATA_SIZE: begin
            if (fetch_rsp.done) begin
               status_in = depth_ok ? whp_pkg::ST_OK : whp_pkg::ST_BAD_DEPTH;
               start_in  = data_begin[13:0];
               stop_in   = data_end[32:0];
               phase_in  = whp_pkg::PH_DONE;
            end
         end
         whp_pkg::PH_DONE: begin
            if (res_take) begin
               phase_in = whp_pkg::PH_LOAD;
            end
         end
         default: begin
            phase_in = whp_pkg::PH_LOAD;
         end
      endcase
   end

   // outputs
   always_comb begin
      fetch_req.start = 1'b0;
      fetch_req.base  = scan_ff;
      fetch_req.last  = whp_pkg::LAST_WORD;
      res_valid       = 1'b0;
      busy            = 1'b1;
      case (phase_ff)
         whp_pkg::PH_LOAD: begin
            busy = 1'b0;
         end
         whp_pkg::PH_RIFF: begin
            fetch_req.start = !sent_ff;
            fetch_req.base  = OW'(0);
         end
         whp_pkg::PH_WAVE: begin
            fetch_req.start = !sent_ff;
            fetch_req.base  = OW'(8);
         end
         whp_pkg::PH_FMT_SEEK, whp_pkg::PH_DATA_SEEK: begin
            fetch_req.start = !sent_ff && !seek_oob;
         end
         whp_pkg::PH_FMT_HOP, whp_pkg::PH_FMT_LEAVE,
         whp_pkg::PH_DATA_HOP, whp_pkg::PH_DATA_SIZE: begin
            fetch_req.start = !sent_ff;
            fetch_req.base  = scan_ff + OW'(4);
         end
         whp_pkg::PH_FMT_CHECK: begin
            fetch_req.start = !sent_ff && !fmt_oob;
            fetch_req.base  = scan_ff + OW'(8);
            fetch_req.last  = whp_pkg::LAST_HALF;
         end
         whp_pkg::PH_CHANS: begin
            fetch_req.start = !sent_ff;
            fetch_req.base  = scan_ff + OW'(10);
            fetch_req.last  = whp_pkg::LAST_HALF;
         end
         whp_pkg::PH_RATE: begin
            fetch_req.start = !sent_ff;
            fetch_req.base  = scan_ff + OW'(12);
         end
         whp_pkg::PH_DEPTH: begin
            fetch_req.start = !sent_ff;
            fetch_req.base  = scan_ff + OW'(22);
            fetch_req.last  = whp_pkg::LAST_HALF;
         end
         whp_pkg::PH_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // error results carry zeros in every other field
   always_comb begin
      res_data = '0;
      res_data.status = status_ff;
      if (status_ff == whp_pkg::ST_OK) begin
         res_data.channel_count = chans_ff;
         res_data.rate_hz       = rate_ff;
         res_data.depth_class   = (depth_ff == whp_pkg::DEPTH_24);
         res_data.data_start    = start_ff;
         res_data.data_stop     = stop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= whp_pkg::PH_LOAD;
         sent_ff  <= 1'b0;
         scan_ff  <= '0;
         chans_ff <= '0;
         rate_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         sent_ff  <= sent_in;
         scan_ff  <= scan_in;
         chans_ff <= chans_in;
         rate_ff  <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      depth_ff  <= depth_in;
      start_ff  <= start_in;
      stop_ff   <= stop_in;
   end

endmodule

// File: rtl/wav_header_chunk_parser.sv
// WAV header parser: byte loading, window memory, chunk walker and result register.
// The req channel takes one file byte per transfer, one per cycle while req_stall
// is low; final_byte marks the last byte of the file head. Up to WINDOW_BYTES bytes
// are kept, later bytes are dropped. After the final byte, req_stall stays high
// while the walker reads the window through the single memory read port.
// Every multi-byte read fetches its bytes one at a time through the read port,
// with a handoff between walker and fetch unit around each read.
// After the final byte's transfer, a clean file with fmt first and data second
// raises rsp_valid, later for every other chunk skipped; failures found before
// the data chunk end earlier.
// One transfer on the rsp channel follows each file: status, stream fields,
// depth class and data offsets (all zero except status on an error).
// The result sits in an output register; while rsp_stall holds it, the walker
// keeps the next result and the req side stays stalled until it can move.
// Loading of the next file starts once the result has left the walker.
// Reset returns to loading with an empty window and no result pending;
// the window memory itself is not cleared.
`timescale 1ns / 1ps
module wav_header_chunk_parser #(
   parameter int WINDOW_BYTES = whp_pkg::WINDOW_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  whp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output whp_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(WINDOW_BYTES);
   localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_BYTES);

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   whp_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   wr_en;
   logic                   walk_busy;
   logic                   res_valid;
   logic                   res_take;
   whp_pkg::rsp_type       res_data;
   whp_pkg::fetch_req_type fetch_req;
   whp_pkg::fetch_rsp_type fetch_rsp;
   logic                   rd_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [7:0]             rd_data;

   assign req_stall = walk_busy;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && (fill_ff < FILL_MAX);
   assign res_take  = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      fill_in = fill_ff;
      if (res_take) begin
         fill_in = '0;
      end else if (wr_en) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   whp_window_ram #(
      .DEPTH  (WINDOW_BYTES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_data.file_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   whp_byte_fetch #(
      .WINDOW_BYTES (WINDOW_BYTES),
      .ADDR_W       (ADDR_W),
      .FILL_W       (FILL_W)
   ) u_fetch (
      .clock      (clock),
      .reset      (reset),
      .fetch_req  (fetch_req),
      .fetch_rsp  (fetch_rsp),
      .fill_count (fill_ff),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   whp_walker #(
      .WINDOW_BYTES (WINDOW_BYTES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .go        (accept && req_data.final_byte),
      .res_take  (res_take),
      .busy      (walk_busy),
      .res_valid (res_valid),
      .res_data  (res_data),
      .fetch_req (fetch_req),
      .fetch_rsp (fetch_rsp)
   );

endmodule

// File: tb/tb_top.sv
// Testbench for the WAV header chunk parser: directed and random file heads against a predictor.
`timescale 1ns / 1ps
module tb_top;

   localparam int WIN_BYTES   = whp_pkg::WINDOW_BYTES_DEF;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int PHASE_BYTES = 450;
   localparam int SETTLE_CYCLES = 200;

   // extra chunk tags, little-endian like the package tags
   localparam logic [31:0] TAG_JUNK = 32'h4B4E_554A;
   localparam logic [31:0] TAG_LIST = 32'h5453_494C;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   whp_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   whp_pkg::rsp_type rsp_data;

   whp_pkg::req_type byte_queue[$];
   whp_pkg::rsp_type pending_results[$];
   whp_pkg::rsp_type head_result;
   logic [7:0] file_img[$];

   // predictor state: window contents, bytes loaded, chunk walk position
   logic [7:0]      win_mem[WIN_BYTES];
   int unsigned     win_fill = 0;
   longint unsigned walk_pos;

   int send_idle_pct = 6;
   int recv_idle_pct = 65;
   int fail_count = 0;
   int cycle_count = 0;

   wav_header_chunk_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // little-endian read; anything past the loaded bytes reads as zero
   function automatic logic [31:0] win_le(longint unsigned at, int nbytes);
      logic [31:0] word;
      word = '0;
      for (int k = 0; k < nbytes; k++) begin
         if (at + k < win_fill && at + k < WIN_BYTES) begin
            word[8*k +: 8] = win_mem[at + k];
         end
      end
      return word;
   endfunction

   function automatic bit seek_chunk(logic [31:0] tag);
      while (walk_pos <= WIN_BYTES - 8) begin
         if (win_le(walk_pos, 4) == tag) begin
            return 1'b1;
         end
         walk_pos += 64'(win_le(walk_pos + 4, 4)) + 64'd8;
      end
      return 1'b0;
   endfunction

   function automatic whp_pkg::rsp_type parse_window();
      whp_pkg::rsp_type r;
      logic [15:0] chans;
      logic [15:0] depth;
      logic [31:0] rate;
      logic [31:0] size;
      longint unsigned start;
      r = '0;
      if (win_le(0, 4) != whp_pkg::TAG_RIFF) begin
         r.status = whp_pkg::ST_NO_RIFF;
         return r;
      end
      if (win_le(8, 4) != whp_pkg::TAG_WAVE) begin
         r.status = whp_pkg::ST_NO_WAVE;
         return r;
      end
      walk_pos = 12;
      if (!seek_chunk(whp_pkg::TAG_FMT)) begin
         r.status = whp_pkg::ST_NO_FMT;
         return r;
      end
      if (walk_pos > WIN_BYTES - 24) begin
         r.status = whp_pkg::ST_FMT_LATE;
         return r;
      end
      if (win_le(walk_pos + 8, 2) != 32'(whp_pkg::FMT_PCM)) begin
         r.status = whp_pkg::ST_NOT_PCM;
         return r;
      end
      chans = 16'(win_le(walk_pos + 10, 2));
      rate  = win_le(walk_pos + 12, 4);
      depth = 16'(win_le(walk_pos + 22, 2));
      walk_pos += 64'(win_le(walk_pos + 4, 4)) + 64'd8;
      if (!seek_chunk(whp_pkg::TAG_DATA)) begin
         r.status = whp_pkg::ST_NO_DATA;
         return r;
      end
      size  = win_le(walk_pos + 4, 4);
      start = walk_pos + 8;
      if (depth != whp_pkg::DEPTH_16 && depth != whp_pkg::DEPTH_24) begin
         r.status = whp_pkg::ST_BAD_DEPTH;
         return r;
      end
      r.status        = whp_pkg::ST_OK;
      r.channel_count = chans;
      r.rate_hz       = rate;
      r.depth_class   = (depth == whp_pkg::DEPTH_24);
      r.data_start    = start[13:0];
      r.data_stop     = 33'(start + 64'(size));
      return r;
   endfunction

   function automatic void take_byte(whp_pkg::req_type item);
      if (win_fill < WIN_BYTES) begin
         win_mem[win_fill] = item.file_byte;
         win_fill++;
      end
      if (item.final_byte) begin
         pending_results.push_back(parse_window());
         win_fill = 0;
      end
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            take_byte(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= byte_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and result check
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with nothing expected, status %0d", rsp_data.status);
               fail_count++;
            end else begin
               head_result = pending_results.pop_front();
               check_field("status", head_result.status, rsp_data.status);
               check_field("channel_count", head_result.channel_count, rsp_data.channel_count);
               check_field("rate_hz", head_result.rate_hz, rsp_data.rate_hz);
               check_field("depth_class", head_result.depth_class, rsp_data.depth_class);
               check_field("data_start", head_result.data_start, rsp_data.data_start);
               check_field("data_stop", head_result.data_stop, rsp_data.data_stop);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic put_le(logic [31:0] value, int nbytes);
      for (int k = 0; k < nbytes; k++) begin
         file_img.push_back(value[8*k +: 8]);
      end
   endtask

   task automatic put_fill(int n);
      repeat (n) file_img.push_back(8'($urandom));
   endtask

   task automatic put_chunk(logic [31:0] tag, logic [31:0] size);
      put_le(tag, 4);
      put_le(size, 4);
   endtask

   task automatic put_head();
      put_le(whp_pkg::TAG_RIFF, 4);
      put_le($urandom, 4);
      put_le(whp_pkg::TAG_WAVE, 4);
   endtask

   task automatic put_fmt(logic [31:0] size, logic [15:0] code, logic [15:0] chans,
                          logic [31:0] rate, logic [15:0] depth);
      put_chunk(whp_pkg::TAG_FMT, size);
      put_le(32'(code), 2);
      put_le(32'(chans), 2);
      put_le(rate, 4);
      put_le($urandom, 4);
      put_le($urandom, 2);
      put_le(32'(depth), 2);
      if (size > 16 && size < 64) begin
         put_fill(int'(size - 16));
      end
   endtask

   task automatic make_clean(logic [15:0] chans, logic [31:0] rate, logic [15:0] depth,
                             logic [31:0] data_size);
      put_head();
      put_fmt(16, whp_pkg::FMT_PCM, chans, rate, depth);
      put_chunk(whp_pkg::TAG_DATA, data_size);
      put_fill(4);
   endtask

   // queue the built file, final mark on its last byte
   task automatic send_file();
      whp_pkg::req_type item;
      foreach (file_img[k]) begin
         item.file_byte  = file_img[k];
         item.final_byte = (k == file_img.size() - 1);
         byte_queue.push_back(item);
      end
      file_img.delete();
   endtask

   task automatic make_random_file();
      int pick;
      int cut;
      int hi;
      logic [15:0] depth;
      logic [15:0] code;
      logic [15:0] chans;
      logic [31:0] rate;
      logic [31:0] size;
      pick = $urandom_range(99);
      if (pick >= 88) begin
         if ($urandom_range(1)) begin
            put_le(whp_pkg::TAG_RIFF, 4);
         end
         put_fill($urandom_range(1, 40));
         return;
      end
      put_head();
      repeat ($urandom_range(2)) begin
         size = $urandom_range(12);
         put_chunk($urandom, size);
         put_fill(size);
      end
      case ($urandom_range(9))
         0, 1, 2, 3: depth = whp_pkg::DEPTH_16;
         4, 5, 6, 7: depth = whp_pkg::DEPTH_24;
         8: depth = 16'($urandom);
         default: depth = $urandom_range(1) ? 16'd8 : 16'd32;
      endcase
      code  = ($urandom_range(19) == 0) ? 16'($urandom) : whp_pkg::FMT_PCM;
      chans = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
      case ($urandom_range(2))
         0: rate = 32'd44100;
         1: rate = 32'd48000;
         default: rate = $urandom;
      endcase
      size = ($urandom_range(3) == 0) ? 32'(16 + $urandom_range(8)) : 32'd16;
      put_fmt(size, code, chans, rate, depth);
      if ($urandom_range(19) == 0) begin
         // chunk that throws the walk past the window
         put_chunk(TAG_LIST, 32'hFFFF_0000 | 32'($urandom));
      end else if ($urandom_range(3) == 0) begin
         size = $urandom_range(10);
         put_chunk(TAG_LIST, size);
         put_fill(size);
      end
      size = $urandom_range(1) ? 32'($urandom_range(4096)) : 32'($urandom);
      put_chunk(whp_pkg::TAG_DATA, size);
      put_fill($urandom_range(8));
      if (pick >= 80) begin
         cut = $urandom_range(1, file_img.size() - 1);
         while (file_img.size() > cut) void'(file_img.pop_back());
      end else if (pick >= 70) begin
         // flip one bit, mostly in the tags and sizes up front
         hi = (file_img.size() > 48) ? 47 : file_img.size() - 1;
         cut = $urandom_range(hi);
         file_img[cut] = file_img[cut] ^ 8'(1 << $urandom_range(7));
      end
   endtask

   task automatic wait_quiet();
      while (byte_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int sent;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      make_clean(16'd2, 32'd44100, whp_pkg::DEPTH_16, 32'd1000);
      send_file();
      make_clean(16'hFFFF, 32'hFFFF_FFFF, whp_pkg::DEPTH_24, 32'hFFFF_FFFF);
      send_file();
      make_clean(16'd0, 32'd0, whp_pkg::DEPTH_16, 32'd0);
      send_file();
      file_img.push_back(8'hFF);
      send_file();
      file_img.push_back(8'h00);
      send_file();
      // RIFF without WAVE
      put_le(whp_pkg::TAG_RIFF, 4);
      put_le(32'd36, 4);
      put_le(whp_pkg::TAG_DATA, 4);
      put_fill(8);
      send_file();
      // no fmt: first chunk jumps past the window
      put_head();
      put_chunk(TAG_JUNK, 32'hFFFF_FFFF);
      put_fill(6);
      send_file();
      put_head();
      put_fmt(16, 16'd3, 16'd2, 32'd48000, whp_pkg::DEPTH_16);
      put_chunk(whp_pkg::TAG_DATA, 32'd64);
      send_file();
      put_head();
      put_fmt(16, 16'hFFFF, 16'd1, 32'd8000, whp_pkg::DEPTH_24);
      put_chunk(whp_pkg::TAG_DATA, 32'd64);
      send_file();
      // fmt fine, data never reached
      put_head();
      put_fmt(16, whp_pkg::FMT_PCM, 16'd1, 32'd8000, whp_pkg::DEPTH_16);
      put_chunk(TAG_LIST, 32'hFFFF_FFF8);
      put_fill(3);
      send_file();
      put_head();
      put_fmt(32'hFFFF_FFFF, whp_pkg::FMT_PCM, 16'd2, 32'd22050, whp_pkg::DEPTH_24);
      put_chunk(whp_pkg::TAG_DATA, 32'd16);
      send_file();
      make_clean(16'd1, 32'd11025, 16'd8, 32'd100);
      send_file();
      make_clean(16'd4, 32'd192000, 16'd32, 32'd100);
      send_file();
      // data ahead of fmt, odd chunk, extended fmt, second data found
      put_head();
      put_chunk(whp_pkg::TAG_DATA, 32'd4);
      put_fill(4);
      put_chunk(TAG_JUNK, 32'd3);
      put_fill(3);
      put_fmt(18, whp_pkg::FMT_PCM, 16'd6, 32'd96000, whp_pkg::DEPTH_24);
      put_chunk(TAG_LIST, 32'd5);
      put_fill(5);
      put_chunk(whp_pkg::TAG_DATA, 32'd12345);
      put_fill(2);
      send_file();
      // file ends inside the fmt body
      put_head();
      put_chunk(whp_pkg::TAG_FMT, 32'd16);
      put_le(32'(whp_pkg::FMT_PCM), 2);
      put_le(32'd2, 1);
      send_file();
      // fmt search hops to the last usable offset and walks out through zeros
      put_head();
      put_chunk(TAG_JUNK, 32'd8148);
      put_fill(4);
      send_file();
      // data search lands on the last usable offset
      put_head();
      put_fmt(16, whp_pkg::FMT_PCM, 16'd1, 32'd16000, whp_pkg::DEPTH_24);
      put_chunk(TAG_JUNK, 32'd8140);
      put_fill(4);
      send_file();
      // one byte further and the walk runs out at once
      put_head();
      put_fmt(16, whp_pkg::FMT_PCM, 16'd1, 32'd16000, whp_pkg::DEPTH_16);
      put_chunk(TAG_JUNK, 32'd8141);
      put_fill(4);
      send_file();

      // hold the sender until every result is out
      wait_quiet();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            make_random_file();
            sent += file_img.size();
            send_file();
         end
         wait_quiet();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
